FILE: sv/bmhq_pkg.sv
// Shared types, constants and the microcode program of the heap queue.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps

package bmhq_pkg;

  localparam int unsigned DEF_CAPACITY = 16;
  localparam int unsigned DEF_KEY_BITS = 32;
  localparam int unsigned FIELD_W = 32;
  localparam int unsigned OCC_W = 5;
  localparam int unsigned STEP_W = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    A_NOP,
    A_ACCEPT,
    A_INS_INIT,
    A_RD_PARENT,
    A_MOVE_PAR,
    A_PLACE,
    A_RD_ROOT,
    A_TAKE_ROOT,
    A_LOAD_CUR,
    A_RD_LEFT,
    A_SAVE_LEFT,
    A_PICK_RIGHT,
    A_MOVE_PICK,
    A_FIN_OK,
    A_FIN_EMPTY,
    A_FIN_FULL
  } act_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_REMOVE,
    C_FULL,
    C_POS_ROOT,
    C_PAR_LE,
    C_EMPTY,
    C_NO_LEFT,
    C_NO_RIGHT,
    C_PICK_GE,
    C_OUT_BUSY
  } cond_e;

  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    step_t target;
    logic  last;
  } ucode_t;

  typedef struct packed {
    logic no_in;
    logic remove;
    logic full;
    logic pos_root;
    logic par_le;
    logic empty;
    logic no_left;
    logic no_right;
    logic pick_ge;
    logic out_busy;
  } flags_t;

  localparam step_t S_IDLE      = 5'd0;
  localparam step_t S_DISPATCH  = 5'd1;
  localparam step_t S_INS_CHK   = 5'd2;
  localparam step_t S_INS_INIT  = 5'd3;
  localparam step_t S_UP_RD     = 5'd4;
  localparam step_t S_UP_CMP    = 5'd5;
  localparam step_t S_UP_MOVE   = 5'd6;
  localparam step_t S_PLACE     = 5'd7;
  localparam step_t S_REM       = 5'd8;
  localparam step_t S_RD_ROOT   = 5'd9;
  localparam step_t S_TAKE_ROOT = 5'd10;
  localparam step_t S_LOAD_CUR  = 5'd11;
  localparam step_t S_DN_LEFT   = 5'd12;
  localparam step_t S_DN_RIGHT  = 5'd13;
  localparam step_t S_DN_PICK   = 5'd14;
  localparam step_t S_DN_CMP    = 5'd15;
  localparam step_t S_DN_MOVE   = 5'd16;
  localparam step_t S_FIN_OK    = 5'd17;
  localparam step_t S_FIN_EMPTY = 5'd18;
  localparam step_t S_FIN_FULL  = 5'd19;

  function automatic ucode_t uw(act_e act, cond_e cond, step_t target, logic last);
    ucode_t w;
    w.act = act;
    w.cond = cond;
    w.target = target;
    w.last = last;
    return w;
  endfunction

  // One control word per step; a taken condition jumps to the target.
  function automatic ucode_t ucode_rom(step_t step);
    ucode_t w;
    case (step)
      S_IDLE:      w = uw(A_ACCEPT,     C_NO_IN,    S_IDLE,      1'b0);
      S_DISPATCH:  w = uw(A_NOP,        C_REMOVE,   S_REM,       1'b0);
      S_INS_CHK:   w = uw(A_NOP,        C_FULL,     S_FIN_FULL,  1'b0);
      S_INS_INIT:  w = uw(A_INS_INIT,   C_NEVER,    S_IDLE,      1'b0);
      S_UP_RD:     w = uw(A_RD_PARENT,  C_POS_ROOT, S_PLACE,     1'b0);
      S_UP_CMP:    w = uw(A_NOP,        C_PAR_LE,   S_PLACE,     1'b0);
      S_UP_MOVE:   w = uw(A_MOVE_PAR,   C_ALWAYS,   S_UP_RD,     1'b0);
      S_PLACE:     w = uw(A_PLACE,      C_ALWAYS,   S_FIN_OK,    1'b0);
      S_REM:       w = uw(A_NOP,        C_EMPTY,    S_FIN_EMPTY, 1'b0);
      S_RD_ROOT:   w = uw(A_RD_ROOT,    C_NEVER,    S_IDLE,      1'b0);
      S_TAKE_ROOT: w = uw(A_TAKE_ROOT,  C_NEVER,    S_IDLE,      1'b0);
      S_LOAD_CUR:  w = uw(A_LOAD_CUR,   C_NEVER,    S_IDLE,      1'b0);
      S_DN_LEFT:   w = uw(A_RD_LEFT,    C_NO_LEFT,  S_PLACE,     1'b0);
      S_DN_RIGHT:  w = uw(A_SAVE_LEFT,  C_NO_RIGHT, S_DN_CMP,    1'b0);
      S_DN_PICK:   w = uw(A_PICK_RIGHT, C_NEVER,    S_IDLE,      1'b0);
      S_DN_CMP:    w = uw(A_NOP,        C_PICK_GE,  S_PLACE,     1'b0);
      S_DN_MOVE:   w = uw(A_MOVE_PICK,  C_ALWAYS,   S_DN_LEFT,   1'b0);
      S_FIN_OK:    w = uw(A_FIN_OK,     C_OUT_BUSY, S_FIN_OK,    1'b1);
      S_FIN_EMPTY: w = uw(A_FIN_EMPTY,  C_OUT_BUSY, S_FIN_EMPTY, 1'b1);
      S_FIN_FULL:  w = uw(A_FIN_FULL,   C_OUT_BUSY, S_FIN_FULL,  1'b1);
      default:     w = uw(A_NOP,        C_ALWAYS,   S_IDLE,      1'b0);
    endcase
    return w;
  endfunction

endpackage

FILE: sv/bmhq_if.sv
// Valid/ready channel interfaces for the request and result words of the heap queue.
// Depends on bmhq_pkg for the operation and status codes.
`timescale 1ns / 1ps

interface bmhq_in_if;
  logic                               valid;
  logic                               ready;
  bmhq_pkg::op_e                      op;
  logic [bmhq_pkg::FIELD_W-1:0]       key;
  logic [bmhq_pkg::FIELD_W-1:0]       payload;

  modport source (output valid, op, key, payload, input ready);
  modport sink (input valid, op, key, payload, output ready);
endinterface

interface bmhq_out_if;
  logic                               valid;
  logic                               ready;
  bmhq_pkg::status_e                  status;
  logic [bmhq_pkg::FIELD_W-1:0]       out_key;
  logic [bmhq_pkg::FIELD_W-1:0]       out_payload;
  logic [bmhq_pkg::OCC_W-1:0]         occupancy;

  modport source (output valid, status, out_key, out_payload, occupancy, input ready);
  modport sink (input valid, status, out_key, out_payload, occupancy, output ready);
endinterface

FILE: sv/bmhq_seq.sv
// Microcode sequencer of the heap queue: step counter, program table and jump logic.
// Depends on bmhq_pkg for the control word, the conditions and the program.
`timescale 1ns / 1ps

module bmhq_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bmhq_pkg::flags_t flags_i,
  output bmhq_pkg::ucode_t uword_o
);
  import bmhq_pkg::*;

  step_t  step_q, step_d;
  ucode_t word;
  logic   hit;

  always_comb begin
    word = ucode_rom(step_q);
    case (word.cond)
      C_NEVER:    hit = 1'b0;
      C_ALWAYS:   hit = 1'b1;
      C_NO_IN:    hit = flags_i.no_in;
      C_REMOVE:   hit = flags_i.remove;
      C_FULL:     hit = flags_i.full;
      C_POS_ROOT: hit = flags_i.pos_root;
      C_PAR_LE:   hit = flags_i.par_le;
      C_EMPTY:    hit = flags_i.empty;
      C_NO_LEFT:  hit = flags_i.no_left;
      C_NO_RIGHT: hit = flags_i.no_right;
      C_PICK_GE:  hit = flags_i.pick_ge;
      C_OUT_BUSY: hit = flags_i.out_busy;
      default:    hit = 1'b1;
    endcase
    if (hit) begin
      step_d = word.target;
    end else if (word.last) begin
      step_d = S_IDLE;
    end else begin
      step_d = step_q + step_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign uword_o = word;

endmodule

FILE: sv/binary_min_heap_queue.sv
// Binary min-heap priority queue of events, top level: datapath, heap memory, result register.
// Depends on bmhq_pkg, the channel interfaces in bmhq_if and the sequencer bmhq_seq.
//
// Each request word on in_i either inserts an event (key and payload) or removes the event
// with the smallest key. Every request gives exactly one result word on out_o: a status,
// the removed key and payload (zero unless a removal succeeded) and the number of events
// held afterwards. An insert into a full queue is dropped with status full; a removal from
// an empty queue returns status empty. Both leave the contents unchanged.
// Requests are handled one at a time by a microcoded sequencer over a single-port heap
// memory, so the next request is accepted only after the last one has reached its result.
// An insert climbs toward the root and a removal sinks the last event from the root; in the
// climb each level costs one parent read and one key compare, in the sink up to two child
// reads and two key compares.
// A finished result sits in an output register; when the receiver stalls, the block still
// takes and works on the next request but holds at its last step until the register frees.
// Reset empties the queue at once, with no clearing pass, and drops any pending result.
`timescale 1ns / 1ps

module binary_min_heap_queue #(
  parameter int unsigned CAPACITY = bmhq_pkg::DEF_CAPACITY,
  parameter int unsigned KEY_BITS = bmhq_pkg::DEF_KEY_BITS
) (
  input logic        clk_i,
  input logic        rst_ni,
  bmhq_in_if.sink    in_i,
  bmhq_out_if.source out_o
);
  import bmhq_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CW = IDX_W + 2;

  ucode_t uword;
  flags_t flags;

  logic [KEY_BITS-1:0] mem_key [CAPACITY];
  logic [FIELD_W-1:0]  mem_pay [CAPACITY];

  logic [CNT_W-1:0]    cnt_q;
  logic [IDX_W-1:0]    pos_q, pick_idx_q;
  op_e                 op_q;
  logic [KEY_BITS-1:0] ikey_q, cur_key_q, pick_key_q, rd_key_q, res_key_q, out_key_q;
  logic [FIELD_W-1:0]  ipay_q, cur_pay_q, pick_pay_q, rd_pay_q, res_pay_q, out_pay_q;
  logic                out_valid_q;
  status_e             out_status_q;
  logic [OCC_W-1:0]    out_occ_q;

  logic [IDX_W-1:0]    par_idx;
  logic [CW-1:0]       left_w, right_w, cnt_w;
  logic                out_busy, fin_load;
  status_e             fin_status;
  logic                rd_en, wr_en;
  logic [IDX_W-1:0]    rd_addr, wr_addr;
  logic [KEY_BITS-1:0] wr_key;
  logic [FIELD_W-1:0]  wr_pay;
  logic [CNT_W+OCC_W-1:0]    occ_ext;
  logic [KEY_BITS+FIELD_W-1:0] okey_ext;

  bmhq_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .uword_o (uword)
  );

  assign par_idx  = (pos_q - IDX_W'(1)) >> 1;
  assign left_w   = {1'b0, pos_q, 1'b1};
  assign right_w  = left_w + CW'(1);
  assign cnt_w    = CW'(cnt_q);
  assign out_busy = out_valid_q && !out_o.ready;
  assign fin_load = ((uword.act == A_FIN_OK) || (uword.act == A_FIN_EMPTY) ||
                     (uword.act == A_FIN_FULL)) && !out_busy;

  always_comb begin
    flags.no_in    = !in_i.valid;
    flags.remove   = (op_q == OP_REMOVE);
    flags.full     = (cnt_q == CNT_W'(CAPACITY));
    flags.pos_root = (pos_q == '0);
    flags.par_le   = !(rd_key_q > cur_key_q);
    flags.empty    = (cnt_q == '0);
    flags.no_left  = (left_w >= cnt_w);
    flags.no_right = (right_w >= cnt_w);
    flags.pick_ge  = !(pick_key_q < cur_key_q);
    flags.out_busy = out_busy;
  end

  always_comb begin
    case (uword.act)
      A_FIN_EMPTY: fin_status = ST_EMPTY;
      A_FIN_FULL:  fin_status = ST_FULL;
      default:     fin_status = ST_OK;
    endcase
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = pos_q;
    wr_key  = cur_key_q;
    wr_pay  = cur_pay_q;
    case (uword.act)
      A_RD_PARENT: begin
        rd_en   = 1'b1;
        rd_addr = par_idx;
      end
      A_RD_ROOT: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      A_TAKE_ROOT: begin
        rd_en   = 1'b1;
        rd_addr = IDX_W'(cnt_q);
      end
      A_RD_LEFT: begin
        rd_en   = 1'b1;
        rd_addr = left_w[IDX_W-1:0];
      end
      A_SAVE_LEFT: begin
        rd_en   = 1'b1;
        rd_addr = right_w[IDX_W-1:0];
      end
      A_MOVE_PAR: begin
        wr_en  = 1'b1;
        wr_key = rd_key_q;
        wr_pay = rd_pay_q;
      end
      A_PLACE: begin
        wr_en = 1'b1;
      end
      A_MOVE_PICK: begin
        wr_en  = 1'b1;
        wr_key = pick_key_q;
        wr_pay = pick_pay_q;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_key[wr_addr] <= wr_key;
      mem_pay[wr_addr] <= wr_pay;
    end
    if (rd_en) begin
      rd_key_q <= mem_key[rd_addr];
      rd_pay_q <= mem_pay[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fin_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (uword.act)
        A_INS_INIT: cnt_q <= cnt_q + CNT_W'(1);
        A_RD_ROOT:  cnt_q <= cnt_q - CNT_W'(1);
        default:    cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (uword.act)
      A_ACCEPT: begin
        if (in_i.valid) begin
          op_q      <= in_i.op;
          ikey_q    <= in_i.key[KEY_BITS-1:0];
          ipay_q    <= in_i.payload;
          res_key_q <= '0;
          res_pay_q <= '0;
        end
      end
      A_INS_INIT: begin
        pos_q     <= cnt_q[IDX_W-1:0];
        cur_key_q <= ikey_q;
        cur_pay_q <= ipay_q;
      end
      A_MOVE_PAR: pos_q <= par_idx;
      A_TAKE_ROOT: begin
        res_key_q <= rd_key_q;
        res_pay_q <= rd_pay_q;
        pos_q     <= '0;
      end
      A_LOAD_CUR: begin
        cur_key_q <= rd_key_q;
        cur_pay_q <= rd_pay_q;
      end
      A_SAVE_LEFT: begin
        pick_key_q <= rd_key_q;
        pick_pay_q <= rd_pay_q;
        pick_idx_q <= left_w[IDX_W-1:0];
      end
      A_PICK_RIGHT: begin
        if (!(pick_key_q < rd_key_q)) begin
          pick_key_q <= rd_key_q;
          pick_pay_q <= rd_pay_q;
          pick_idx_q <= right_w[IDX_W-1:0];
        end
      end
      A_MOVE_PICK: pos_q <= pick_idx_q;
      default: begin
        pos_q <= pos_q;
      end
    endcase
    if (fin_load) begin
      out_status_q <= fin_status;
      out_key_q    <= res_key_q;
      out_pay_q    <= res_pay_q;
      out_occ_q    <= occ_ext[OCC_W-1:0];
    end
  end

  assign occ_ext  = {{OCC_W{1'b0}}, cnt_q};
  assign okey_ext = {{FIELD_W{1'b0}}, out_key_q};

  assign in_i.ready        = (uword.act == A_ACCEPT);
  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.out_key     = okey_ext[FIELD_W-1:0];
  assign out_o.out_payload = out_pay_q;
  assign out_o.occupancy   = out_occ_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("event count exceeds capacity");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_load && (uword.act == A_FIN_FULL)) |-> (cnt_q == CNT_W'(CAPACITY)))
    else $error("full status reported while the queue has room");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_load && (uword.act == A_FIN_EMPTY)) |-> (cnt_q == '0))
    else $error("empty status reported while the queue holds events");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(cnt_q) |-> ((cnt_q == $past(cnt_q) + CNT_W'(1)) ||
                         (cnt_q + CNT_W'(1) == $past(cnt_q))))
    else $error("event count changed by more than one");

endmodule
